// ===== hw/rtl/morse_beacon_keyer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Morse beacon keyer assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef MORSE_BEACON_KEYER_TOP_DEFINES_SVH
`define MORSE_BEACON_KEYER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked on every clock edge out of reset
`define MBK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen
`define MBK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MBK_ASSERT(lbl, clk, rst_n, prop, msg)
`define MBK_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/mbk_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse beacon keyer package
// Sizes, codes and reset values shared by the keyer RTL.
// ----------------------------------------------------------------------------
package mbk_pkg;

    // Message store geometry and timing multipliers
    localparam int MSG_DEPTH = 64;
    localparam int MSG_AW    = $clog2(MSG_DEPTH);
    localparam int DAH_MULT  = 3;
    localparam int WORD_MULT = 7;

    // Field widths
    localparam int ACT_W  = 2;
    localparam int SLOT_W = 6;
    localparam int BYTE_W = 8;
    localparam int DIT_W  = 16;
    localparam int TONE_W = 8;
    localparam int PH_W   = 3;
    localparam int IDX_W  = 6;
    localparam int REM_W  = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [PH_W-1:0]   t_phase;
    typedef logic [BYTE_W-1:0] t_byte;

    // Actions
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    // Phases
    localparam t_phase PH_IDLE = 3'd0;
    localparam t_phase PH_DIT  = 3'd1;
    localparam t_phase PH_DAH  = 3'd2;
    localparam t_phase PH_EGAP = 3'd3;
    localparam t_phase PH_CGAP = 3'd4;
    localparam t_phase PH_WGAP = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUAL_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_LVL  = 2'd2;

    // Pattern byte markers
    localparam t_byte EOC_MARK   = 8'h80;
    localparam t_byte SPACE_MARK = 8'hFF;

    // Reset values
    localparam logic [DIT_W-1:0]  DIT_RST  = 16'd1500;
    localparam logic [TONE_W-1:0] MARK_RST = 8'd100;
    localparam logic [TONE_W-1:0] TONE_RST = 8'd255;

endpackage

// ===== hw/rtl/morse_beacon_keyer_top.sv =====
// An accepted item's result beat is registered in the output register, or in the skid slot while the output stalls.
// One item is taken per cycle while the skid slot is empty; stall rises only while the skid slot holds a beat.
// The rate is set by the read-modify-write of the keyer state and store prefetch.
// Reset is synchronous, active low; the message store reads as empty at once through
// per-entry valid bits, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// Morse beacon keyer top level
// Tick-driven repeating Morse beacon with a 64-byte pattern store.
// ----------------------------------------------------------------------------
`include "morse_beacon_keyer_top_defines.svh"

module morse_beacon_keyer_top
    import mbk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [BYTE_W-1:0]     i_pattern_byte,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_key_on,
    output logic [TONE_W-1:0]     o_tone_level,
    output logic [PH_W-1:0]       o_phase,
    output logic [IDX_W-1:0]      o_char_index
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIT_W-1:0]  r_dit;
    logic              r_dual;
    logic [TONE_W-1:0] r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit  <= DIT_RST;
            r_dual <= 1'b0;
            r_mark <= MARK_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DIT_TICKS: r_dit  <= i_cfg_wdata[DIT_W-1:0];
                CFG_DUAL_FREQ: r_dual <= i_cfg_wdata[0];
                CFG_MARK_LVL:  r_mark <= i_cfg_wdata[TONE_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_skid_valid;
    logic w_in_acc;
    logic w_out_acc;

    assign o_in_stall = r_skid_valid;
    assign w_in_acc   = i_in_valid && !r_skid_valid;
    assign w_out_acc  = r_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // Keyer state
    // ------------------------------------------------------------------
    logic [MSG_AW-1:0] r_pos,   n_pos;
    t_byte             r_pat,   n_pat;
    t_phase            r_phase, n_phase;
    logic [REM_W-1:0]  r_rem,   n_rem;
    logic              r_key,   n_key;
    logic [TONE_W-1:0] r_tone,  n_tone;

    function automatic logic [MSG_AW-1:0] f_pos_inc(input logic [MSG_AW-1:0] p);
        logic [MSG_AW-1:0] q;
        if (p == MSG_AW'(MSG_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Message store: one write port, one registered read port.
    // The read port always fetches the entry after the next position, so
    // the byte that follows the current position is ready on any tick.
    // Slot zero is also kept in a shadow register for message start.
    // ------------------------------------------------------------------
    t_byte             r_mem [MSG_DEPTH];
    t_byte             r_mem_q;
    logic [MSG_DEPTH-1:0] r_valid;
    logic              r_rd_valid;
    logic              r_fwd;
    t_byte             r_fwd_data;
    t_byte             r_first;
    logic              w_wr_en;
    logic [MSG_AW-1:0] w_wr_addr;
    logic [MSG_AW-1:0] w_rd_addr;
    t_byte             w_nx_byte;

    assign w_wr_en   = w_in_acc && (i_action == ACT_WRITE) && (32'(i_slot) < MSG_DEPTH);
    assign w_wr_addr = MSG_AW'(i_slot);
    assign w_rd_addr = f_pos_inc(n_pos);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_pattern_byte;
        end
        r_mem_q    <= r_mem[w_rd_addr];
        r_fwd_data <= i_pattern_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_first    <= '0;
        end else begin
            if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (w_wr_en && (w_wr_addr == '0)) begin
                r_first <= i_pattern_byte;
            end
            r_rd_valid <= r_valid[w_rd_addr];
            // a write to the entry being fetched bypasses the array read
            r_fwd      <= w_wr_en && (w_wr_addr == w_rd_addr);
        end
    end

    // byte at the slot after the current position; never-written entries read zero
    assign w_nx_byte = r_fwd ? r_fwd_data : (r_rd_valid ? r_mem_q : '0);

    // ------------------------------------------------------------------
    // Phase lengths (constant multiples of one dit)
    // ------------------------------------------------------------------
    logic [REM_W-1:0] w_len_dit;
    logic [REM_W-1:0] w_len_dah;
    logic [REM_W-1:0] w_len_word;

    assign w_len_dit  = REM_W'(r_dit);
    assign w_len_dah  = REM_W'(32'(r_dit) * DAH_MULT);
    assign w_len_word = REM_W'(32'(r_dit) * WORD_MULT);

    // ------------------------------------------------------------------
    // Next element choice
    // ------------------------------------------------------------------
    t_byte             w_pat_cur;
    logic [MSG_AW-1:0] w_ch_pos;
    t_byte             w_ch_pat;
    t_phase            w_ch_phase;
    logic [REM_W-1:0]  w_ch_rem;

    // at the start of the message, load slot zero
    assign w_pat_cur = ((r_pos == '0) && (r_pat == '0)) ? r_first : r_pat;

    always_comb begin
        w_ch_pos   = r_pos;
        w_ch_pat   = w_pat_cur;
        w_ch_phase = PH_WGAP;
        w_ch_rem   = w_len_word;
        if (w_pat_cur == '0) begin
            // end of message: loop back after a word gap
            w_ch_pos = '0;
            w_ch_pat = '0;
        end else if (w_pat_cur == EOC_MARK) begin
            w_ch_phase = PH_CGAP;
            w_ch_rem   = w_len_dah;
            w_ch_pos   = f_pos_inc(r_pos);
            w_ch_pat   = w_nx_byte;
        end else if (w_pat_cur == SPACE_MARK) begin
            w_ch_pos = f_pos_inc(r_pos);
            w_ch_pat = w_nx_byte;
        end else begin
            // take the top bit as the element, shift it out
            w_ch_phase = w_pat_cur[BYTE_W-1] ? PH_DAH : PH_DIT;
            w_ch_rem   = w_pat_cur[BYTE_W-1] ? w_len_dah : w_len_dit;
            w_ch_pat   = {w_pat_cur[BYTE_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // State update for one accepted beat
    // ------------------------------------------------------------------
    always_comb begin
        n_pos   = r_pos;
        n_pat   = r_pat;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_key   = r_key;
        n_tone  = r_tone;
        if (w_in_acc) begin
            unique case (i_action)
                ACT_TICK: begin
                    if ((r_phase == PH_IDLE) ||
                        ((r_rem == '0) && (r_phase != PH_DIT) && (r_phase != PH_DAH))) begin
                        n_pos   = w_ch_pos;
                        n_pat   = w_ch_pat;
                        n_phase = w_ch_phase;
                        n_rem   = w_ch_rem;
                    end else if (r_rem == '0) begin
                        // element over: key follows the mode, then an element gap
                        n_key   = r_dual;
                        n_tone  = '0;
                        n_phase = PH_EGAP;
                        n_rem   = w_len_dit;
                    end else begin
                        n_rem = r_rem - 1'b1;
                    end
                    if ((n_phase == PH_DIT) || (n_phase == PH_DAH)) begin
                        n_key  = 1'b1;
                        n_tone = r_dual ? r_mark : '0;
                    end else if (n_phase != PH_IDLE) begin
                        n_tone = '0;
                    end
                end
                ACT_WRITE: ;  // store write only
                ACT_RESTART: begin
                    n_pos   = '0;
                    n_pat   = '0;
                    n_phase = PH_IDLE;
                end
                default: ;  // unused action: state holds
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_pat   <= '0;
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_key   <= 1'b1;
            r_tone  <= TONE_RST;
        end else begin
            r_pos   <= n_pos;
            r_pat   <= n_pat;
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_key   <= n_key;
            r_tone  <= n_tone;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid slot
    // ------------------------------------------------------------------
    logic              r_out_key,   r_skid_key;
    logic [TONE_W-1:0] r_out_tone,  r_skid_tone;
    t_phase            r_out_phase, r_skid_phase;
    logic [IDX_W-1:0]  r_out_idx,   r_skid_idx;
    logic              w_load_main;
    logic              w_load_skid;
    logic              w_pop_skid;

    // skid is full only with main full, and no beat is accepted then
    assign w_pop_skid  = w_out_acc && r_skid_valid;
    assign w_load_main = w_in_acc && (!r_out_valid || w_out_acc);
    assign w_load_skid = w_in_acc && r_out_valid && !w_out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop_skid) begin
                r_skid_valid <= 1'b0;
            end else if (w_load_skid) begin
                r_skid_valid <= 1'b1;
            end
            if (w_pop_skid || w_load_main) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_skid) begin
            r_out_key   <= r_skid_key;
            r_out_tone  <= r_skid_tone;
            r_out_phase <= r_skid_phase;
            r_out_idx   <= r_skid_idx;
        end else if (w_load_main) begin
            r_out_key   <= n_key;
            r_out_tone  <= n_tone;
            r_out_phase <= n_phase;
            r_out_idx   <= IDX_W'(n_pos);
        end
        if (w_load_skid) begin
            r_skid_key   <= n_key;
            r_skid_tone  <= n_tone;
            r_skid_phase <= n_phase;
            r_skid_idx   <= IDX_W'(n_pos);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_on     = r_out_key;
    assign o_tone_level = r_out_tone;
    assign o_phase      = r_out_phase;
    assign o_char_index = r_out_idx;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MBK_ASSERT_NEVER(a_skid_without_main, i_clk, i_rst_n, r_skid_valid && !r_out_valid, "skid slot full while output register empty")
    `MBK_ASSERT(a_element_keyed, i_clk, i_rst_n, (r_out_valid && ((r_out_phase == PH_DIT) || (r_out_phase == PH_DAH))) |-> r_out_key, "element beat without key on")
    `MBK_ASSERT(a_restart_clears, i_clk, i_rst_n, (w_in_acc && (i_action == ACT_RESTART)) |=> ((r_phase == PH_IDLE) && (r_pos == '0) && (r_pat == '0)), "restart did not return to message start")

endmodule
